@@ rtl/earliest_free_machine_dispatcher_unit_assert.svh @@
// Assertion macros shared by the dispatcher RTL.
`ifndef EARLIEST_FREE_MACHINE_DISPATCHER_UNIT_ASSERT_SVH
`define EARLIEST_FREE_MACHINE_DISPATCHER_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define EFMD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define EFMD_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ rtl/efmd_pkg.sv @@
// Package with types, field layout and codes of the earliest-free-machine dispatcher.
package efmd_pkg;

	localparam int MACHINES_DEF = 16;
	localparam int PRODUCTS_DEF = 1024;

	localparam int OP_W    = 2;
	localparam int PROD_W  = 10;
	localparam int MACH_W  = 4;
	localparam int SETUP_W = 8;
	localparam int QTY_W   = 16;
	localparam int FIN_W   = 32;
	localparam int RATE_W  = 8;

	// Slave tdata layout, lowest bit first.
	localparam int PROD_LSB  = 0;
	localparam int MACH_LSB  = PROD_LSB + PROD_W;
	localparam int SETUP_LSB = MACH_LSB + MACH_W;
	localparam int QTY_LSB   = SETUP_LSB + SETUP_W;
	localparam int S_USED_W  = QTY_LSB + QTY_W;
	localparam int S_DATA_W  = ((S_USED_W + 7) / 8) * 8;

	// Master tdata layout, lowest bit first.
	localparam int M_USED_W = MACH_W + FIN_W + 1;
	localparam int M_DATA_W = ((M_USED_W + 7) / 8) * 8;
	localparam int M_PAD_W  = M_DATA_W - M_USED_W;

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(10);
	localparam logic [FIN_W-1:0]  FIN_MAX    = {FIN_W{1'b1}};

	localparam int DIV_CNT_W = $clog2(QTY_W + 1);

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_SCHED = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_SETUP_RD,
		ST_SUM,
		ST_FREAD,
		ST_FREAD_WAIT,
		ST_EMIT
	} efmd_state_t;

	typedef struct packed {
		logic              start;
		logic [QTY_W-1:0]  dividend;
		logic [RATE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QTY_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ rtl/efmd_div.sv @@
// Restoring divider: quantity by machine rate, one quotient bit per cycle.
module efmd_div (
	input  logic                clk,
	input  logic                arst_n,
	input  efmd_pkg::div_req_t  req,
	output efmd_pkg::div_rsp_t  rsp
);

	logic [efmd_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [efmd_pkg::RATE_W-1:0]    rem_q;
	logic [efmd_pkg::RATE_W-1:0]    div_q;
	logic [efmd_pkg::QTY_W-1:0]     quo_q;
	logic [efmd_pkg::RATE_W:0]      rem_sh;
	logic                           fits;

	assign rem_sh = {rem_q, quo_q[efmd_pkg::QTY_W-1]};
	assign fits   = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == efmd_pkg::DIV_CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= efmd_pkg::DIV_CNT_W'(efmd_pkg::QTY_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - efmd_pkg::DIV_CNT_W'(1);
				if (cnt_q == efmd_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// A zero rate divides as a rate of one.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= (req.divisor == '0) ? efmd_pkg::RATE_W'(1) : req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[efmd_pkg::QTY_W-2:0], fits};
			rem_q <= fits ? efmd_pkg::RATE_W'(rem_sh - {1'b0, div_q})
			              : rem_sh[efmd_pkg::RATE_W-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ rtl/earliest_free_machine_dispatcher_unit.sv @@
// Top level of the earliest-free-machine dispatcher.
// Requests arrive on the slave stream: tuser carries the operation (load setup entry,
// schedule order, read finish time) and tdata the product, machine, setup and quantity.
// Each request gives exactly one result on the master stream: chosen machine, finish
// time and a saturation flag. The machine rate register is written through cfg_wr_en
// and cfg_wr_data; the user must write it only while no request is in flight, as
// the block itself does not enforce this. In a schedule the finish times are scanned
// through the single read port of the finish-time memory, one machine per cycle, and
// the quantity is then divided by the rate in the divider at one bit per cycle.
// Only one request is in progress at a time; s_tready is high while the sequencer is
// idle. The result sits in an output register, so the next request is accepted while
// an earlier result still waits for m_tready; a second result waits in the sequencer.
// Reset clears every finish time to zero (through valid bits, without a sweep), sets
// the rate to ten and empties the output register. Setup entries are undefined until
// they are loaded.
module earliest_free_machine_dispatcher_unit #(
	parameter int MACHINES = efmd_pkg::MACHINES_DEF,
	parameter int PRODUCTS = efmd_pkg::PRODUCTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// product_index, machine_index, setup_hours, quantity, zero padding
	input  logic [efmd_pkg::S_DATA_W-1:0] s_tdata,
	// op
	input  logic [efmd_pkg::OP_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// chosen_machine, finish_time, saturated, zero padding
	output logic [efmd_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                          cfg_wr_en,
	input  logic [efmd_pkg::RATE_W-1:0]   cfg_wr_data
);

	`include "earliest_free_machine_dispatcher_unit_assert.svh"

	localparam int MW          = (MACHINES > 1) ? $clog2(MACHINES) : 1;
	localparam int CW          = $clog2(MACHINES + 1);
	localparam int SETUP_DEPTH = PRODUCTS * MACHINES;
	localparam int AW          = (SETUP_DEPTH > 1) ? $clog2(SETUP_DEPTH) : 1;
	localparam int SUM_W       = efmd_pkg::FIN_W + 2;

	efmd_pkg::efmd_state_t state_q, state_d;

	// Request fields.
	logic [efmd_pkg::PROD_W-1:0]  in_prod;
	logic [efmd_pkg::MACH_W-1:0]  in_mach;
	logic [efmd_pkg::SETUP_W-1:0] in_setup;
	logic [efmd_pkg::QTY_W-1:0]   in_qty;
	logic                         in_mach_ok;
	logic                         in_prod_ok;
	logic                         accept;

	logic [efmd_pkg::RATE_W-1:0]  rate_q;
	logic [efmd_pkg::PROD_W-1:0]  prod_q;
	logic [efmd_pkg::MACH_W-1:0]  mach_q;
	logic [efmd_pkg::QTY_W-1:0]   qty_q;
	logic                         prod_ok_q;
	logic                         mach_ok_q;

	// Finish-time memory with reset-cleared valid bits.
	logic [efmd_pkg::FIN_W-1:0]   fin_mem [MACHINES];
	logic [MACHINES-1:0]          fin_valid_q;
	logic [efmd_pkg::FIN_W-1:0]   fin_rd_q;
	logic                         rd_valid_q;
	logic [efmd_pkg::FIN_W-1:0]   fin_data;
	logic [MW-1:0]                fin_raddr;
	logic                         fin_re;
	logic                         fin_we;

	// Scan of the finish times.
	logic [CW-1:0]                scan_cnt_q;
	logic                         cmp_vld_q;
	logic [MW-1:0]                cmp_idx_q;
	logic [efmd_pkg::FIN_W-1:0]   best_val_q;
	logic [MW-1:0]                best_idx_q;
	logic                         scan_issue;
	logic                         scan_done;

	// Setup table.
	logic [efmd_pkg::SETUP_W-1:0] setup_mem [SETUP_DEPTH];
	logic [efmd_pkg::SETUP_W-1:0] setup_rd_q;
	logic [AW-1:0]                setup_waddr;
	logic [AW-1:0]                setup_raddr;
	logic                         setup_we;
	logic                         setup_re;

	efmd_pkg::div_req_t           div_req;
	efmd_pkg::div_rsp_t           div_rsp;

	logic [SUM_W-1:0]             sum;
	logic                         sum_sat;
	logic [efmd_pkg::FIN_W-1:0]   sum_fin;

	logic [efmd_pkg::MACH_W-1:0]  res_mach_q;
	logic [efmd_pkg::FIN_W-1:0]   res_fin_q;
	logic                         res_sat_q;

	logic                         out_load;
	logic                         out_vld_q;
	logic [efmd_pkg::MACH_W-1:0]  out_mach_q;
	logic [efmd_pkg::FIN_W-1:0]   out_fin_q;
	logic                         out_sat_q;

	assign in_prod  = s_tdata[efmd_pkg::PROD_LSB +: efmd_pkg::PROD_W];
	assign in_mach  = s_tdata[efmd_pkg::MACH_LSB +: efmd_pkg::MACH_W];
	assign in_setup = s_tdata[efmd_pkg::SETUP_LSB +: efmd_pkg::SETUP_W];
	assign in_qty   = s_tdata[efmd_pkg::QTY_LSB +: efmd_pkg::QTY_W];

	assign in_mach_ok = 32'(in_mach) < 32'(MACHINES);
	assign in_prod_ok = 32'(in_prod) < 32'(PRODUCTS);
	assign accept     = s_tvalid && s_tready;

	assign fin_data  = rd_valid_q ? fin_rd_q : '0;
	assign scan_done = (state_q == efmd_pkg::ST_SCAN) && cmp_vld_q &&
	                   (cmp_idx_q == MW'(MACHINES - 1));

	assign setup_waddr = AW'(32'(in_prod) * 32'(MACHINES) + 32'(MW'(in_mach)));
	assign setup_raddr = AW'(32'(prod_q) * 32'(MACHINES) + 32'(best_idx_q));
	assign setup_we    = accept && (efmd_pkg::op_t'(s_tuser) == efmd_pkg::OP_LOAD) &&
	                     in_mach_ok && in_prod_ok;

	// A product outside the table takes no setup time.
	assign sum = SUM_W'(best_val_q) + SUM_W'(div_rsp.quotient) +
	             SUM_W'(prod_ok_q ? setup_rd_q : '0);
	assign sum_sat = |sum[SUM_W-1:efmd_pkg::FIN_W];
	assign sum_fin = sum_sat ? efmd_pkg::FIN_MAX : sum[efmd_pkg::FIN_W-1:0];

	assign div_req.start    = scan_done;
	assign div_req.dividend = qty_q;
	assign div_req.divisor  = rate_q;

	efmd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			efmd_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					unique case (efmd_pkg::op_t'(s_tuser))
						efmd_pkg::OP_SCHED: state_d = efmd_pkg::ST_SCAN;
						efmd_pkg::OP_READ:  state_d = efmd_pkg::ST_FREAD;
						default:            state_d = efmd_pkg::ST_EMIT;
					endcase
				end
			end
			efmd_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = efmd_pkg::ST_DIV;
				end
			end
			efmd_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = efmd_pkg::ST_SETUP_RD;
				end
			end
			efmd_pkg::ST_SETUP_RD:   state_d = efmd_pkg::ST_SUM;
			efmd_pkg::ST_SUM:        state_d = efmd_pkg::ST_EMIT;
			efmd_pkg::ST_FREAD:      state_d = efmd_pkg::ST_FREAD_WAIT;
			efmd_pkg::ST_FREAD_WAIT: state_d = efmd_pkg::ST_EMIT;
			efmd_pkg::ST_EMIT: begin
				if (!out_vld_q || m_tready) begin
					state_d = efmd_pkg::ST_IDLE;
				end
			end
			default: state_d = efmd_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready   = 1'b0;
		fin_re     = 1'b0;
		fin_we     = 1'b0;
		fin_raddr  = scan_cnt_q[MW-1:0];
		scan_issue = 1'b0;
		setup_re   = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			efmd_pkg::ST_IDLE: s_tready = 1'b1;
			efmd_pkg::ST_SCAN: begin
				scan_issue = scan_cnt_q < CW'(MACHINES);
				fin_re     = scan_issue;
			end
			efmd_pkg::ST_SETUP_RD: setup_re = 1'b1;
			efmd_pkg::ST_SUM:      fin_we   = 1'b1;
			efmd_pkg::ST_FREAD: begin
				fin_re    = 1'b1;
				fin_raddr = MW'(mach_q);
			end
			efmd_pkg::ST_EMIT: out_load = !out_vld_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= efmd_pkg::ST_IDLE;
			rate_q      <= efmd_pkg::RATE_RESET;
			fin_valid_q <= '0;
			cmp_vld_q   <= 1'b0;
			scan_cnt_q  <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			cmp_vld_q <= scan_issue;
			if (cfg_wr_en) begin
				rate_q <= cfg_wr_data;
			end
			if (accept) begin
				scan_cnt_q <= '0;
			end else if (scan_issue) begin
				scan_cnt_q <= scan_cnt_q + CW'(1);
			end
			if (fin_we) begin
				fin_valid_q[best_idx_q] <= 1'b1;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Memories.
	always_ff @(posedge clk) begin
		if (fin_we) begin
			fin_mem[best_idx_q] <= sum_fin;
		end
		if (fin_re) begin
			fin_rd_q   <= fin_mem[fin_raddr];
			rd_valid_q <= fin_valid_q[fin_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (setup_we) begin
			setup_mem[setup_waddr] <= in_setup;
		end
		if (setup_re) begin
			setup_rd_q <= setup_mem[setup_raddr];
		end
	end

	// Request capture, scan compare and result staging.
	always_ff @(posedge clk) begin
		if (accept) begin
			prod_q    <= in_prod;
			mach_q    <= in_mach;
			qty_q     <= in_qty;
			prod_ok_q <= in_prod_ok;
			mach_ok_q <= in_mach_ok;
			res_fin_q <= '0;
			res_sat_q <= 1'b0;
			res_mach_q <= (efmd_pkg::op_t'(s_tuser) == efmd_pkg::OP_LOAD ||
			               efmd_pkg::op_t'(s_tuser) == efmd_pkg::OP_READ) ? in_mach : '0;
		end
		cmp_idx_q <= scan_cnt_q[MW-1:0];
		// Strictly smaller wins, so ties stay with the lowest machine.
		if (cmp_vld_q && (cmp_idx_q == '0 || fin_data < best_val_q)) begin
			best_val_q <= fin_data;
			best_idx_q <= cmp_idx_q;
		end
		if (state_q == efmd_pkg::ST_SUM) begin
			res_mach_q <= efmd_pkg::MACH_W'(best_idx_q);
			res_fin_q  <= sum_fin;
			res_sat_q  <= sum_sat;
		end
		if (state_q == efmd_pkg::ST_FREAD_WAIT) begin
			res_fin_q <= mach_ok_q ? fin_data : '0;
		end
		if (out_load) begin
			out_mach_q <= res_mach_q;
			out_fin_q  <= res_fin_q;
			out_sat_q  <= res_sat_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{efmd_pkg::M_PAD_W{1'b0}}, out_sat_q, out_fin_q, out_mach_q};

	`EFMD_ASSERT(a_sched_starts_scan,
		(accept && efmd_pkg::op_t'(s_tuser) == efmd_pkg::OP_SCHED) |=>
		(state_q == efmd_pkg::ST_SCAN),
		"schedule request did not start the finish-time scan")
	`EFMD_ASSERT(a_div_done_in_div,
		div_rsp.done |-> (state_q == efmd_pkg::ST_DIV),
		"divider finished outside the divide step")
	`EFMD_ASSERT(a_sat_means_max,
		(m_tvalid && out_sat_q) |-> (out_fin_q == efmd_pkg::FIN_MAX),
		"saturated result without the maximum finish time")
	`EFMD_ASSERT(a_write_marks_valid,
		(state_q == efmd_pkg::ST_SUM) |=> fin_valid_q[$past(best_idx_q)],
		"finish-time write left its entry invalid")
	`EFMD_ASSERT_NEVER(a_no_divider_overlap,
		div_req.start && div_rsp.busy,
		"divider restarted while busy")

endmodule

@@ tb/sv/tb_earliest_free_machine_dispatcher_unit.sv @@
// Self-checking testbench for the earliest-free-machine dispatcher.
module tb_earliest_free_machine_dispatcher_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [efmd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RES_FIN_LSB     = efmd_pkg::MACH_W;
	localparam int RES_SAT_BIT     = efmd_pkg::MACH_W + efmd_pkg::FIN_W;
	localparam int PHASES          = 6;
	localparam int PHASE_REQUESTS  = 320;
	localparam int PRESSURE_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 5000;

	typedef struct packed {
		logic [efmd_pkg::MACH_W-1:0] machine;
		logic [efmd_pkg::FIN_W-1:0]  finish;
		logic                        saturated;
	} dispatch_t;

	// Mirrors the machine finish times, the setup table and the rate, and keeps the
	// dispatches still owed by the block in request order.
	class dispatch_book;
		logic [efmd_pkg::FIN_W-1:0]   finish_at [efmd_pkg::MACHINES_DEF];
		logic [efmd_pkg::SETUP_W-1:0] setup_hours [efmd_pkg::MACHINES_DEF *
		                                           efmd_pkg::PRODUCTS_DEF];
		logic [efmd_pkg::RATE_W-1:0]  rate;
		dispatch_t                    awaited [$];
		int                           mismatches;
		int                           checked;

		function new();
			foreach (finish_at[i]) finish_at[i] = '0;
			foreach (setup_hours[i]) setup_hours[i] = '0;
			rate       = efmd_pkg::RATE_RESET;
			mismatches = 0;
			checked    = 0;
		endfunction

		function void take_request(logic [efmd_pkg::OP_W-1:0] op,
			logic [efmd_pkg::S_DATA_W-1:0] data);
			logic [efmd_pkg::PROD_W-1:0]  prod;
			logic [efmd_pkg::MACH_W-1:0]  mach;
			logic [efmd_pkg::SETUP_W-1:0] setup;
			logic [efmd_pkg::QTY_W-1:0]   qty;
			logic [efmd_pkg::SETUP_W-1:0] st;
			logic [efmd_pkg::RATE_W-1:0]  divisor;
			logic [efmd_pkg::FIN_W+1:0]   total;
			dispatch_t                    want;
			int                           best;
			int                           i;
			prod  = data[efmd_pkg::PROD_LSB +: efmd_pkg::PROD_W];
			mach  = data[efmd_pkg::MACH_LSB +: efmd_pkg::MACH_W];
			setup = data[efmd_pkg::SETUP_LSB +: efmd_pkg::SETUP_W];
			qty   = data[efmd_pkg::QTY_LSB +: efmd_pkg::QTY_W];
			want  = '0;
			if (op == efmd_pkg::OP_LOAD) begin
				want.machine = mach;
				if (int'(mach) < efmd_pkg::MACHINES_DEF && int'(prod) < efmd_pkg::PRODUCTS_DEF)
					setup_hours[int'(prod) * efmd_pkg::MACHINES_DEF + int'(mach)] = setup;
			end else if (op == efmd_pkg::OP_SCHED) begin
				best = 0;
				for (i = 1; i < efmd_pkg::MACHINES_DEF; i++)
					if (finish_at[i] < finish_at[best])
						best = i;
				st = '0;
				if (int'(prod) < efmd_pkg::PRODUCTS_DEF)
					st = setup_hours[int'(prod) * efmd_pkg::MACHINES_DEF + best];
				// A zero rate adds the whole quantity.
				divisor = (rate == '0) ? efmd_pkg::RATE_W'(1) : rate;
				total   = finish_at[best] + qty / divisor + st;
				if (total > efmd_pkg::FIN_MAX) begin
					total          = efmd_pkg::FIN_MAX;
					want.saturated = 1'b1;
				end
				want.machine      = best[efmd_pkg::MACH_W-1:0];
				want.finish       = total[efmd_pkg::FIN_W-1:0];
				finish_at[best]   = want.finish;
			end else if (op == efmd_pkg::OP_READ) begin
				want.machine = mach;
				if (int'(mach) < efmd_pkg::MACHINES_DEF)
					want.finish = finish_at[mach];
			end
			awaited.insert(awaited.size(), want);
		endfunction

		function void check_result(logic [efmd_pkg::M_DATA_W-1:0] data);
			dispatch_t got;
			dispatch_t want;
			got.machine   = data[efmd_pkg::MACH_W-1:0];
			got.finish    = data[RES_FIN_LSB +: efmd_pkg::FIN_W];
			got.saturated = data[RES_SAT_BIT];
			if (awaited.size() == 0) begin
				$error("result with no request outstanding: chosen_machine %0d finish_time %0d",
					got.machine, got.finish);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (got.machine !== want.machine) begin
				$error("chosen_machine: expected %0d, got %0d", want.machine, got.machine);
				mismatches++;
			end
			if (got.finish !== want.finish) begin
				$error("finish_time: expected %0d, got %0d", want.finish, got.finish);
				mismatches++;
			end
			if (got.saturated !== want.saturated) begin
				$error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
				mismatches++;
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [efmd_pkg::S_DATA_W-1:0] s_tdata;
	logic [efmd_pkg::OP_W-1:0]     s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [efmd_pkg::M_DATA_W-1:0] m_tdata;
	logic                          cfg_wr_en;
	logic [efmd_pkg::RATE_W-1:0]   cfg_wr_data;

	dispatch_book book = new();

	// Generator-side record of which setup entries hold a value, so that a schedule
	// only names products whose whole row has been loaded.
	bit entry_loaded [efmd_pkg::MACHINES_DEF * efmd_pkg::PRODUCTS_DEF];
	int row_fill [efmd_pkg::PRODUCTS_DEF];
	int ready_rows [$];

	int  op_seen [4];
	int  quiet;
	int  send_calm;
	int  rates_used;
	bit  pressure_go;
	bit  pressure_done;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	earliest_free_machine_dispatcher_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	function automatic int next_idle(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4)
			calm = $urandom_range(20, 60);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 15);
		return $urandom_range(40, 160);
	endfunction

	// Both handshakes are sampled here, and the watchdog counts cycles without either.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				book.take_request(s_tuser, s_tdata);
				op_seen[s_tuser]++;
			end
			if (m_tvalid && m_tready)
				book.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet <= 0;
			end else if (quiet + 1 >= WATCHDOG_LIMIT) begin
				$error("no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// Result side: random stalls, plus one long hold-off while requests keep coming.
	initial begin
		int hold;
		int calm;
		m_tready <= 1'b0;
		calm = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (pressure_go && !pressure_done) begin
				m_tready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
				pressure_done = 1'b1;
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				hold = next_idle(calm);
				if (hold > 0) begin
					m_tready <= 1'b0;
					repeat (hold) @(posedge clk);
				end
			end
		end
	end

	task automatic send_request(logic [efmd_pkg::OP_W-1:0] op,
		logic [efmd_pkg::PROD_W-1:0] prod, logic [efmd_pkg::MACH_W-1:0] mach,
		logic [efmd_pkg::SETUP_W-1:0] setup, logic [efmd_pkg::QTY_W-1:0] qty);
		int gap;
		int slot;
		if (op == efmd_pkg::OP_LOAD) begin
			slot = int'(prod) * efmd_pkg::MACHINES_DEF + int'(mach);
			if (!entry_loaded[slot]) begin
				entry_loaded[slot] = 1'b1;
				row_fill[prod]++;
				if (row_fill[prod] == efmd_pkg::MACHINES_DEF)
					ready_rows.insert(ready_rows.size(), int'(prod));
			end
		end
		gap = next_idle(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= efmd_pkg::S_DATA_W'({qty, setup, mach, prod});
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic load_row(logic [efmd_pkg::PROD_W-1:0] prod);
		int m;
		for (m = 0; m < efmd_pkg::MACHINES_DEF; m++)
			send_request(efmd_pkg::OP_LOAD, prod, efmd_pkg::MACH_W'(m),
				efmd_pkg::SETUP_W'($urandom), efmd_pkg::QTY_W'($urandom));
	endtask

	// Stops the sender and waits until every request has had its result.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (book.awaited.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_orders(int count);
		int sent_here;
		int r;
		logic [efmd_pkg::QTY_W-1:0] qty;
		sent_here = 0;
		while (sent_here < count) begin
			r = $urandom_range(0, 99);
			if (ready_rows.size() < 3 || r < 5) begin
				load_row(efmd_pkg::PROD_W'($urandom));
				sent_here += efmd_pkg::MACHINES_DEF;
			end else begin
				if (r < 17) begin
					send_request(efmd_pkg::OP_LOAD, efmd_pkg::PROD_W'($urandom),
						efmd_pkg::MACH_W'($urandom), efmd_pkg::SETUP_W'($urandom),
						efmd_pkg::QTY_W'($urandom));
				end else if (r < 27) begin
					send_request(efmd_pkg::OP_READ, efmd_pkg::PROD_W'($urandom),
						efmd_pkg::MACH_W'($urandom), efmd_pkg::SETUP_W'($urandom),
						efmd_pkg::QTY_W'($urandom));
				end else if (r < 30) begin
					send_request(OP_UNUSED, efmd_pkg::PROD_W'($urandom),
						efmd_pkg::MACH_W'($urandom), efmd_pkg::SETUP_W'($urandom),
						efmd_pkg::QTY_W'($urandom));
				end else begin
					r = $urandom_range(0, 99);
					qty = (r < 10) ? '0 : (r < 20) ? '1 : efmd_pkg::QTY_W'($urandom);
					send_request(efmd_pkg::OP_SCHED,
						efmd_pkg::PROD_W'(ready_rows[$urandom_range(0, ready_rows.size() - 1)]),
						efmd_pkg::MACH_W'($urandom), efmd_pkg::SETUP_W'($urandom), qty);
				end
				sent_here++;
			end
		end
	endtask

	initial begin
		int phase;
		logic [efmd_pkg::RATE_W-1:0] rate;
		s_tvalid    <= 1'b0;
		s_tuser     <= '0;
		s_tdata     <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		arst_n      <= 1'b0;
		send_calm     = 0;
		pressure_go   = 1'b0;
		pressure_done = 1'b0;
		rates_used    = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening at the reset rate: top product row, setup extremes, ties
		// between idle machines, largest and smallest quantities, a quantity below the
		// rate, reads of the edge machines and the unused operation.
		load_row('1);
		send_request(efmd_pkg::OP_LOAD, '1, '0, '1, '0);
		send_request(efmd_pkg::OP_LOAD, '1, '1, '0, '1);
		send_request(efmd_pkg::OP_SCHED, '1, '0, '0, '1);
		send_request(efmd_pkg::OP_SCHED, '1, '1, '1, '0);
		send_request(efmd_pkg::OP_SCHED, '1, '0, '0, efmd_pkg::QTY_W'(9));
		send_request(efmd_pkg::OP_READ, '0, '0, '0, '0);
		send_request(efmd_pkg::OP_READ, '1, '1, '1, '1);
		send_request(OP_UNUSED, '1, '1, '1, '1);
		send_request(efmd_pkg::OP_LOAD, '0, '1, '0, '1);

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				case (phase)
					1:       rate = '1;
					2:       rate = efmd_pkg::RATE_W'(1);
					3:       rate = '0;
					default: rate = efmd_pkg::RATE_W'($urandom_range(2, 254));
				endcase
				settle();
				cfg_wr_en   <= 1'b1;
				cfg_wr_data <= rate;
				@(posedge clk);
				cfg_wr_en <= 1'b0;
				book.rate = rate;
				rates_used++;
			end
			if (phase == 2)
				pressure_go = 1'b1;
			run_orders(PHASE_REQUESTS);
		end

		settle();
		repeat (60) @(posedge clk);
		$display("Requests accepted: %0d loads, %0d schedules, %0d reads, %0d unused;",
			op_seen[efmd_pkg::OP_LOAD], op_seen[efmd_pkg::OP_SCHED],
			op_seen[efmd_pkg::OP_READ], op_seen[OP_UNUSED]);
		$display("%0d results checked over %0d rate settings; long output hold-off %s.",
			book.checked, rates_used, pressure_done ? "applied" : "not applied");
		if (book.mismatches == 0 && book.awaited.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/efmd_pkg.sv
rtl/efmd_div.sv
rtl/earliest_free_machine_dispatcher_unit.sv
tb/sv/tb_earliest_free_machine_dispatcher_unit.sv
